// File: rtl/core/cba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

  // pool geometry
  localparam int NumBlocks = 256;
  localparam int IdxW      = $clog2(NumBlocks);
  localparam int CntW      = IdxW + 1;
  localparam int BytesW    = 20;
  localparam int BsW       = 13;
  localparam int DivStepW  = $clog2(BytesW);

  localparam logic [BsW-1:0] BsReset = BsW'(64);

  // register map, one register at byte address 0
  localparam int PaddrW = 3;
  localparam logic RegBlockSize = 1'b0;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_RESIZE = 2'd1,
    REQ_FREE   = 2'd2,
    REQ_BAD    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_INPLACE = 2'd0,
    ST_PLACED  = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]        req;
    logic [IdxW-1:0]   handle;
    logic [BytesW-1:0] nblocks;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/cba_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  handle_block;
  logic [19:0] size_bytes;
  modport source (output valid, req_type, handle_block, size_bytes, input ready);
  modport sink (input valid, req_type, handle_block, size_bytes, output ready);
endinterface

interface cba_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] start_block;
  logic [8:0] current_usage;
  logic [8:0] peak_usage;
  modport source (output valid, status, start_block, current_usage, peak_usage,
                  input ready);
  modport sink (input valid, status, start_block, current_usage, peak_usage,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/cba_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_front import cba_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [BsW-1:0] block_size_i,
  cba_req_if.sink             req_i,
  output logic                push_valid_o,
  input  wire logic           push_ready_i,
  output cmd_t                push_cmd_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e             state_q, state_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic [BytesW-1:0]   dvd_q, dvd_d;
  logic [BytesW-1:0]   quo_q, quo_d;
  logic [BsW-1:0]      rem_q, rem_d;
  logic [BsW-1:0]      dvs_q, dvs_d;
  logic [1:0]          req_q, req_d;
  logic [IdxW-1:0]     handle_q, handle_d;
  logic [BsW:0]        rem_sh;
  logic                rem_ge;

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  // round up: quotient plus one when a remainder is left
  always_comb begin
    push_cmd_o.req     = req_q;
    push_cmd_o.handle  = handle_q;
    push_cmd_o.nblocks = quo_q + BytesW'(rem_q != '0);
  end

  // one restoring step per cycle
  assign rem_sh = {rem_q, dvd_q[BytesW-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    req_d    = req_q;
    handle_d = handle_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          req_d    = req_i.req_type;
          handle_d = req_i.handle_block;
          dvd_d    = req_i.size_bytes;
          dvs_d    = (block_size_i == '0) ? BsW'(1) : block_size_i;
          rem_d    = '0;
          quo_d    = '0;
          step_d   = '0;
          state_d  = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = rem_ge ? BsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[BsW-1:0];
        quo_d  = {quo_q[BytesW-2:0], rem_ge};
        dvd_d  = {dvd_q[BytesW-2:0], 1'b0};
        step_d = step_q + DivStepW'(1);
        if (step_q == DivStepW'(BytesW - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    req_q    <= req_d;
    handle_q <= handle_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/cba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_queue import cba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

// File: rtl/core/cba_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_back import cba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  input  cmd_t      pop_cmd_i,
  cba_rsp_if.source rsp_o
);

  typedef enum logic [5:0] {
    B_IDLE    = 6'b000001,
    B_DECIDE  = 6'b000010,
    B_GROWCHK = 6'b000100,
    B_SEARCH  = 6'b001000,
    B_FILL    = 6'b010000,
    B_OUT     = 6'b100000
  } bstate_e;

  bstate_e             state_q, state_d;
  logic [NumBlocks-1:0] used_q, used_d;
  logic [NumBlocks-1:0] len_vld_q, len_vld_d;
  logic [CntW-1:0]     len_mem [NumBlocks];
  logic [CntW-1:0]     rd_len_q;
  logic                rd_vld_q;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [CntW-1:0]     mem_wdata;

  logic [IdxW-1:0]     cursor_q, cursor_d;
  logic [CntW-1:0]     usage_q, usage_d, peak_q, peak_d;
  cmd_t                cmd_q, cmd_d;
  logic [CntW-1:0]     old_q, old_d, nlen_q, nlen_d;
  logic [CntW-1:0]     pos_q, pos_d, cnt_q, cnt_d, cand_q, cand_d;
  logic                wrap_q, wrap_d;
  logic [CntW-1:0]     fbase_q, fbase_d, fcnt_q, fcnt_d;
  logic                fset_q, fset_d, relp_q, relp_d;
  status_e             status_q, status_d;
  logic [IdxW-1:0]     start_q, start_d;

  logic                rsp_vld_q;
  status_e             rsp_status_q;
  logic [IdxW-1:0]     rsp_start_q;
  logic [CntW-1:0]     rsp_cur_q, rsp_peak_q;
  logic                out_load;

  // decoded view of the current command
  logic                big;
  logic [CntW-1:0]     nw9, old_v, grow_add, usage_sum;
  logic [CntW:0]       grow_end, cur_sum;
  logic [IdxW:0]       h9;

  assign big      = (cmd_q.nblocks > BytesW'(NumBlocks));
  assign nw9      = cmd_q.nblocks[CntW-1:0];
  assign old_v    = rd_vld_q ? rd_len_q : '0;
  assign h9       = {1'b0, cmd_q.handle};
  assign grow_end = {1'b0, h9} + {1'b0, nw9};
  assign grow_add = nw9 - old_q;
  assign cur_sum  = {1'b0, cursor_q} + {1'b0, nlen_q} ;
  assign usage_sum = usage_q + nlen_q;

  assign pop_ready_o = (state_q == B_IDLE);
  assign out_load    = (state_q == B_OUT) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    len_vld_d = len_vld_q;
    mem_we    = 1'b0;
    mem_waddr = cmd_q.handle;
    mem_wdata = nw9;
    cursor_d  = cursor_q;
    usage_d   = usage_q;
    peak_d    = peak_q;
    cmd_d     = cmd_q;
    old_d     = old_q;
    nlen_d    = nlen_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    cand_d    = cand_q;
    wrap_d    = wrap_q;
    fbase_d   = fbase_q;
    fcnt_d    = fcnt_q;
    fset_d    = fset_q;
    relp_d    = relp_q;
    status_d  = status_q;
    start_d   = start_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          cmd_d    = pop_cmd_i;
          start_d  = '0;
          status_d = ST_INVALID;
          state_d  = B_OUT;
          case (req_e'(pop_cmd_i.req))
            REQ_ALLOC: begin
              if (pop_cmd_i.nblocks == '0) begin
                state_d = B_OUT;
              end else if (pop_cmd_i.nblocks > BytesW'(NumBlocks)) begin
                status_d = ST_NOSPACE;
              end else begin
                nlen_d  = pop_cmd_i.nblocks[CntW-1:0];
                pos_d   = {1'b0, cursor_q};
                cand_d  = {1'b0, cursor_q};
                cnt_d   = '0;
                wrap_d  = 1'b0;
                relp_d  = 1'b0;
                state_d = B_SEARCH;
              end
            end
            REQ_RESIZE, REQ_FREE: state_d = B_DECIDE;
            default: state_d = B_OUT;
          endcase
        end
      end

      // run length of the handle is now in the read register
      B_DECIDE: begin
        old_d   = old_v;
        start_d = cmd_q.handle;
        status_d = ST_INPLACE;
        if (old_v == '0) begin
          status_d = ST_INVALID;
          start_d  = '0;
          state_d  = B_OUT;
        end else if (cmd_q.req == REQ_FREE || cmd_q.nblocks == '0) begin
          len_vld_d[cmd_q.handle] = 1'b0;
          usage_d = usage_q - old_v;
          fbase_d = h9;
          fcnt_d  = old_v;
          fset_d  = 1'b0;
          relp_d  = 1'b0;
          state_d = B_FILL;
        end else if (!big && nw9 == old_v) begin
          state_d = B_OUT;
        end else if (!big && nw9 < old_v) begin
          // shrink: drop the tail
          mem_we  = 1'b1;
          usage_d = usage_q - (old_v - nw9);
          fbase_d = h9 + nw9;
          fcnt_d  = old_v - nw9;
          fset_d  = 1'b0;
          relp_d  = 1'b0;
          state_d = B_FILL;
        end else if (big) begin
          status_d = ST_NOSPACE;
          start_d  = '0;
          state_d  = B_OUT;
        end else if (grow_end > (CntW+1)'(NumBlocks)) begin
          nlen_d  = nw9;
          pos_d   = {1'b0, cursor_q};
          cand_d  = {1'b0, cursor_q};
          cnt_d   = '0;
          wrap_d  = 1'b0;
          relp_d  = 1'b1;
          state_d = B_SEARCH;
        end else begin
          pos_d   = h9 + old_v;
          cnt_d   = nw9 - old_v;
          state_d = B_GROWCHK;
        end
      end

      // blocks after the run, one per cycle
      B_GROWCHK: begin
        if (used_q[pos_q[IdxW-1:0]]) begin
          nlen_d  = nw9;
          pos_d   = {1'b0, cursor_q};
          cand_d  = {1'b0, cursor_q};
          cnt_d   = '0;
          wrap_d  = 1'b0;
          relp_d  = 1'b1;
          state_d = B_SEARCH;
        end else if (cnt_q == CntW'(1)) begin
          mem_we  = 1'b1;
          usage_d = usage_q + grow_add;
          peak_d  = ((usage_q + grow_add) > peak_q) ? usage_q + grow_add : peak_q;
          fbase_d = h9 + old_q;
          fcnt_d  = grow_add;
          fset_d  = 1'b1;
          relp_d  = 1'b0;
          state_d = B_FILL;
        end else begin
          pos_d = pos_q + CntW'(1);
          cnt_d = cnt_q - CntW'(1);
        end
      end

      // next-fit scan: from the cursor to the end, then from 0 up to the cursor
      B_SEARCH: begin
        if (pos_q == CntW'(NumBlocks)) begin
          if (wrap_q) begin
            status_d = ST_NOSPACE;
            start_d  = '0;
            state_d  = B_OUT;
          end else begin
            wrap_d = 1'b1;
            pos_d  = '0;
            cand_d = '0;
            cnt_d  = '0;
          end
        end else if (wrap_q && cand_q >= {1'b0, cursor_q}) begin
          status_d = ST_NOSPACE;
          start_d  = '0;
          state_d  = B_OUT;
        end else if (used_q[pos_q[IdxW-1:0]]) begin
          cand_d = pos_q + CntW'(1);
          cnt_d  = '0;
          pos_d  = pos_q + CntW'(1);
        end else if (cnt_q + CntW'(1) == nlen_q) begin
          mem_we    = 1'b1;
          mem_waddr = cand_q[IdxW-1:0];
          mem_wdata = nlen_q;
          len_vld_d[cand_q[IdxW-1:0]] = 1'b1;
          cursor_d  = cur_sum >= (CntW+1)'(NumBlocks) ? '0 : cur_sum[IdxW-1:0];
          usage_d   = usage_sum;
          peak_d    = (usage_sum > peak_q) ? usage_sum : peak_q;
          fbase_d   = cand_q;
          fcnt_d    = nlen_q;
          fset_d    = 1'b1;
          status_d  = ST_PLACED;
          start_d   = cand_q[IdxW-1:0];
          state_d   = B_FILL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          pos_d = pos_q + CntW'(1);
        end
      end

      // one bitmap entry per cycle, then the old run when moving
      B_FILL: begin
        used_d[fbase_q[IdxW-1:0]] = fset_q;
        if (fcnt_q == CntW'(1)) begin
          if (relp_q) begin
            relp_d  = 1'b0;
            len_vld_d[cmd_q.handle] = 1'b0;
            usage_d = usage_q - old_q;
            fbase_d = h9;
            fcnt_d  = old_q;
            fset_d  = 1'b0;
          end else begin
            state_d = B_OUT;
          end
        end else begin
          fbase_d = fbase_q + CntW'(1);
          fcnt_d  = fcnt_q - CntW'(1);
        end
      end

      B_OUT: begin
        if (out_load) state_d = B_IDLE;
      end

      default: state_d = B_IDLE;
    endcase
  end

  // control state and tables with a reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      used_q    <= '0;
      len_vld_q <= '0;
      cursor_q  <= '0;
      usage_q   <= '0;
      peak_q    <= '0;
      relp_q    <= 1'b0;
      wrap_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      len_vld_q <= len_vld_d;
      cursor_q  <= cursor_d;
      usage_q   <= usage_d;
      peak_q    <= peak_d;
      relp_q    <= relp_d;
      wrap_q    <= wrap_d;
      if (out_load)          rsp_vld_q <= 1'b1;
      else if (rsp_o.ready)  rsp_vld_q <= 1'b0;
    end
  end

  // run length memory, read at the queue head
  always_ff @(posedge clk_i) begin
    if (mem_we) len_mem[mem_waddr] <= mem_wdata;
    rd_len_q <= len_mem[pop_cmd_i.handle];
    rd_vld_q <= len_vld_q[pop_cmd_i.handle];
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    old_q    <= old_d;
    nlen_q   <= nlen_d;
    pos_q    <= pos_d;
    cnt_q    <= cnt_d;
    cand_q   <= cand_d;
    fbase_q  <= fbase_d;
    fcnt_q   <= fcnt_d;
    fset_q   <= fset_d;
    status_q <= status_d;
    start_q  <= start_d;
    if (out_load) begin
      rsp_status_q <= status_q;
      rsp_start_q  <= start_q;
      rsp_cur_q    <= usage_q;
      rsp_peak_q   <= peak_q;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.start_block   = rsp_start_q;
  assign rsp_o.current_usage = rsp_cur_q;
  assign rsp_o.peak_usage    = rsp_peak_q;

endmodule
`default_nettype wire

// File: rtl/core/contiguous_block_allocator.sv
// Next-fit contiguous block allocator over a pool of 256 blocks. Each request
// beat (allocate, resize, free) is first converted from bytes to blocks by a
// bit-serial divider in the front end, then queued (two entries) and executed
// by the back end, which walks the used-block bitmap one block a cycle. An
// allocate scans from the cursor to the pool end and then from 0 up to the
// cursor, then marks the blocks of the new run; a move on resize also clears
// the blocks of the old run. Free and shrink clear the blocks that they
// release; an in-place grow first checks each block to be added, then marks
// them.
// The front end takes the next request while the back end is still busy, and
// a finished result sits in an output register until taken. block_size must
// be written over the APB port at address 0 only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_block_allocator import cba_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cba_req_if.sink                req_i,
  cba_rsp_if.source              rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [BsW-1:0] block_size_q;
  logic           front_valid, front_ready, back_valid, back_ready;
  cmd_t           front_cmd, back_cmd;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBlockSize) ? {{(32-BsW){1'b0}}, block_size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BsReset;
    end else if (psel && penable && pwrite && paddr[2] == RegBlockSize) begin
      block_size_q <= pwdata[BsW-1:0];
    end
  end

  cba_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .block_size_i (block_size_q),
    .req_i        (req_i),
    .push_valid_o (front_valid),
    .push_ready_i (front_ready),
    .push_cmd_o   (front_cmd)
  );

  cba_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  cba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (back_valid),
    .pop_ready_o (back_ready),
    .pop_cmd_i   (back_cmd),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/cba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cba_assertions import cba_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] status,
  input wire logic [7:0] start_block,
  input wire logic [8:0] current_usage,
  input wire logic [8:0] peak_usage
);

  // a stalled result beat keeps its status and start block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(start_block))
    else $error("result beat changed while stalled");

  // failed requests report start block zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status == ST_NOSPACE || status == ST_INVALID) |-> start_block == '0)
    else $error("failed request with nonzero start block");

  // peak never below current usage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> peak_usage >= current_usage)
    else $error("peak usage below current usage");

  // usage stays within the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> current_usage <= 9'(NumBlocks))
    else $error("usage beyond pool size");

endmodule

bind contiguous_block_allocator cba_assertions u_cba_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .status        (rsp_o.status),
  .start_block   (rsp_o.start_block),
  .current_usage (rsp_o.current_usage),
  .peak_usage    (rsp_o.peak_usage)
);
`default_nettype wire

// File: dv/cba_checker.sv
`timescale 1ns / 1ps
module cba_checker import cba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cba_req_if                req,
  cba_rsp_if                rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output logic [255:0]      live_runs
);

  typedef struct packed {
    status_e    status;
    logic [7:0] start;
    logic [8:0] cur;
    logic [8:0] peak;
  } alloc_result_t;

  // shadow of the pool
  logic [BsW-1:0] bs_q;
  logic [255:0]   used_q;
  int             run_len [256];
  int             cursor;
  int             usage;
  int             peak;
  alloc_result_t  expected_q [$];

  function automatic int bytes_to_blocks(int bytes);
    int bs;
    bs = (bs_q == 0) ? 1 : int'(bs_q);
    return (bytes + bs - 1) / bs;
  endfunction

  function automatic void count_up(int n);
    usage += n;
    if (usage > peak) peak = usage;
  endfunction

  function automatic bit span_free(int s, int n);
    if (n > NumBlocks || s > NumBlocks - n) return 0;
    for (int i = 0; i < n; i++) if (used_q[s+i]) return 0;
    return 1;
  endfunction

  // next-fit search from the cursor, wrapping once
  function automatic bit find_run(int n, output int where);
    int s;
    s = cursor % NumBlocks;
    where = 0;
    for (int k = 0; k < NumBlocks; k++) begin
      if (span_free(s, n)) begin
        for (int i = 0; i < n; i++) used_q[s+i] = 1'b1;
        run_len[s] = n;
        cursor += n;
        if (cursor >= NumBlocks) cursor = 0;
        count_up(n);
        where = s;
        return 1;
      end
      s = (s + 1 >= NumBlocks) ? 0 : s + 1;
    end
    return 0;
  endfunction

  function automatic void drop_run(int s);
    int n;
    n = run_len[s];
    for (int i = 0; i < n && s + i < NumBlocks; i++) used_q[s+i] = 1'b0;
    run_len[s] = 0;
    usage -= n;
  endfunction

  function automatic alloc_result_t serve_request(logic [1:0] kind, int h, int bytes);
    alloc_result_t r;
    int where, old, nw;
    r.status = ST_INVALID;
    r.start  = '0;
    if (kind == REQ_ALLOC) begin
      if (bytes != 0) begin
        if (find_run(bytes_to_blocks(bytes), where)) begin
          r.status = ST_PLACED;
          r.start  = where[7:0];
        end else begin
          r.status = ST_NOSPACE;
        end
      end
    end else if ((kind == REQ_RESIZE || kind == REQ_FREE) && run_len[h] != 0) begin
      old = run_len[h];
      nw  = (kind == REQ_FREE) ? 0 : bytes_to_blocks(bytes);
      r.status = ST_INPLACE;
      r.start  = h[7:0];
      if (nw == 0) begin
        drop_run(h);
      end else if (nw < old) begin
        for (int i = nw; i < old; i++) used_q[h+i] = 1'b0;
        run_len[h] = nw;
        usage -= old - nw;
      end else if (nw > old) begin
        if (span_free(h + old, nw - old) && nw <= NumBlocks && h <= NumBlocks - nw) begin
          for (int i = old; i < nw; i++) used_q[h+i] = 1'b1;
          run_len[h] = nw;
          count_up(nw - old);
        end else if (find_run(nw, where)) begin
          drop_run(h);
          r.status = ST_PLACED;
          r.start  = where[7:0];
        end else begin
          r.status = ST_NOSPACE;
          r.start  = '0;
        end
      end
    end
    r.cur  = usage[8:0];
    r.peak = peak[8:0];
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 256; i++) live_runs[i] = (run_len[i] != 0);
  end

  // predict on request beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t e;
    if (!rst_ni) begin
      bs_q   = BsReset;
      used_q = '0;
      foreach (run_len[i]) run_len[i] = 0;
      cursor = 0;
      usage  = 0;
      peak   = 0;
      expected_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result beat with nothing outstanding", $realtime);
        end else begin
          e = expected_q.pop_front();
          if (rsp.status !== e.status || rsp.start_block !== e.start ||
              rsp.current_usage !== e.cur || rsp.peak_usage !== e.peak) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp st=%0d start=%0d cur=%0d peak=%0d, got st=%0d start=%0d cur=%0d peak=%0d",
                       $realtime, e.status, e.start, e.cur, e.peak, rsp.status,
                       rsp.start_block, rsp.current_usage, rsp.peak_usage);
          end
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(serve_request(req.req_type, int'(req.handle_block),
                                           int'(req.size_bytes)));
      if (psel && penable && pwrite && pready && paddr == PaddrW'(4 * RegBlockSize))
        bs_q = pwdata[BsW-1:0];
      pending = expected_q.size();
    end
  end

endmodule

// File: dv/contiguous_block_allocator_tb.sv
`timescale 1ns / 1ps
module contiguous_block_allocator_tb import cba_pkg::*;;

  localparam int WatchdogLimit = 20000;
  localparam int LongStall     = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int errors, pending;
  logic [255:0] live_runs;
  int snd_idle = 8, rcv_idle = 87;
  int stall_asked = 0;
  int cur_bs = 64;

  cba_req_if req ();
  cba_rsp_if rsp ();

  contiguous_block_allocator i_dut (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cba_checker i_checker (
    .clk_i, .rst_ni, .req, .rsp, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .errors, .pending, .live_runs
  );

  always #5 clk_i = ~clk_i;

  // result side, with one long hold-off when a stall is asked for
  initial rsp.ready = 1'b0;
  always @(negedge clk_i) begin
    int stall_seen, hold_left;
    if (stall_asked != stall_seen) begin
      stall_seen = stall_asked;
      hold_left  = LongStall;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    int quiet;
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] kind, logic [7:0] h, logic [19:0] bytes);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.req_type     <= kind;
    req.handle_block <= h;
    req.size_bytes   <= bytes;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_block_size(int value);
    drain();
    repeat (10) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * RegBlockSize);
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_bs = value;
  endtask

  function automatic logic [7:0] pick_live();
    int r;
    r = $urandom_range(255);
    for (int i = 0; i < 256; i++)
      if (live_runs[(r + i) % 256]) return 8'((r + i) % 256);
    return 8'(r);
  endfunction

  function automatic logic [19:0] sized_bytes();
    int bs, nblk;
    longint b;
    bs = (cur_bs == 0) ? 1 : cur_bs;
    case ($urandom_range(19))
      0:       nblk = $urandom_range(300, 200);
      1, 2:    nblk = $urandom_range(64, 13);
      default: nblk = $urandom_range(12, 1);
    endcase
    b = longint'(nblk) * bs - $urandom_range(bs - 1);
    if (b > 20'hFFFFF) b = 20'hFFFFF;
    return 20'(b);
  endfunction

  task automatic random_beat();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)      send_beat(REQ_ALLOC, 8'($urandom), sized_bytes());
    else if (pick < 65) send_beat(REQ_RESIZE, pick_live(),
                                  ($urandom_range(9) == 0) ? 20'd0 : sized_bytes());
    else if (pick < 90) send_beat(REQ_FREE, pick_live(), 20'($urandom));
    else if (pick < 94) send_beat(REQ_BAD, 8'($urandom), 20'($urandom));
    else if (pick < 97) send_beat(REQ_ALLOC, 8'($urandom), 20'd0);
    else                send_beat(logic'($urandom_range(1)) ? REQ_FREE : REQ_RESIZE,
                                  8'($urandom), 20'($urandom));
  endtask

  initial begin
    int sizes [6] = '{1, 4096, 0, 8191, 300, 64};
    req.valid = 1'b0;
    req.req_type = REQ_ALLOC;
    req.handle_block = '0;
    req.size_bytes = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through every operation at the reset block size
    send_beat(REQ_ALLOC, 8'd0, 20'd1);
    send_beat(REQ_ALLOC, 8'd0, 20'd64);
    send_beat(REQ_ALLOC, 8'd0, 20'd65);
    send_beat(REQ_ALLOC, 8'd0, 20'hFFFFF);
    send_beat(REQ_ALLOC, 8'd0, 20'd0);
    send_beat(REQ_BAD, 8'd255, 20'hFFFFF);
    send_beat(REQ_FREE, 8'd255, 20'd0);
    send_beat(REQ_RESIZE, 8'd2, 20'd128);
    send_beat(REQ_RESIZE, 8'd2, 20'd1);
    send_beat(REQ_RESIZE, 8'd2, 20'd192);
    send_beat(REQ_RESIZE, 8'd0, 20'd128);
    send_beat(REQ_RESIZE, 8'd5, 20'd0);
    send_beat(REQ_FREE, 8'd1, 20'hFFFFF);
    send_beat(REQ_FREE, 8'd1, 20'd0);
    send_beat(REQ_FREE, 8'd2, 20'd0);
    send_beat(REQ_ALLOC, 8'd0, 20'd16384);
    send_beat(REQ_ALLOC, 8'd0, 20'd1);
    send_beat(REQ_RESIZE, 8'd0, 20'd16448);
    send_beat(REQ_FREE, 8'd0, 20'd0);

    // random phases over several block sizes and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_block_size(sizes[ph]);
      if (ph == 2) begin
        snd_idle = 87;
        rcv_idle = 8;
      end else if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
        stall_asked++;
      end
      for (int n = 0; n < 75; n++) begin
        if (ph == 3 && n == 40) drain();
        random_beat();
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cba_pkg.sv
rtl/core/cba_if.sv
rtl/core/cba_front.sv
rtl/core/cba_queue.sv
rtl/core/cba_back.sv
rtl/core/contiguous_block_allocator.sv
rtl/core/cba_checker.sv
dv/cba_checker.sv
dv/contiguous_block_allocator_tb.sv
